FILE: hdl/sqd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scalar quantizer distortion unit.
// No dependencies; imported by the controller, the datapath and the top level.
package sqd_pkg;

   // Field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int CODE_W     = 16;
   localparam int INDEX_W    = 2;
   localparam int VALUE_W    = 18;   // sample or code word plus headroom for the difference
   localparam int ABS_W      = 17;
   localparam int SQ_W       = 2 * ABS_W;
   localparam int SUM_W      = 48;
   localparam int MEAN_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_THRESH = 3;
   localparam int NUM_CODES  = 4;

   // Register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_THRESHOLD_0  = 3'd0,
      CSR_THRESHOLD_1  = 3'd1,
      CSR_THRESHOLD_2  = 3'd2,
      CSR_CODE_VALUE_0 = 3'd3,
      CSR_CODE_VALUE_1 = 3'd4,
      CSR_CODE_VALUE_2 = 3'd5,
      CSR_CODE_VALUE_3 = 3'd6
   } sqd_csr_type;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_0_RESET  = 16'hC000;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_1_RESET  = 16'h0000;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_2_RESET  = 16'h4000;
   localparam logic [CSR_DATA_W-1:0] CODE_VALUE_0_RESET = 16'hA000;
   localparam logic [CSR_DATA_W-1:0] CODE_VALUE_1_RESET = 16'hE000;
   localparam logic [CSR_DATA_W-1:0] CODE_VALUE_2_RESET = 16'h2000;
   localparam logic [CSR_DATA_W-1:0] CODE_VALUE_3_RESET = 16'h6000;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;     // take the input beat, compare and select the code word
      logic square;      // square the error
      logic accumulate;  // update sum and count, load the divider on a last beat
      logic div_step;    // one restoring division step
      logic emit;        // load the output register
   } sqd_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic last;        // captured item closes a run
      logic div_last;    // final division step is being taken
   } sqd_status_type;

endpackage

FILE: hdl/sqd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the scalar quantizer distortion unit: handshakes and datapath commands.
// Depends on sqd_pkg.
module sqd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sqd_pkg::sqd_cmd_type    cmd,
   input  sqd_pkg::sqd_status_type status
);
   import sqd_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SQUARE,
      ACCUM,
      DIVIDE,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output register can take a result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = SQUARE;
         end
         SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ACCUM;
         end
         ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = status.last ? DIVIDE : EMIT;
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = EMIT;
         end
         EMIT: begin
            cmd.emit = out_free;
            if (out_free) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Set on a load, drop once the beat is taken
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted beat blocks the input until its result is loaded
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepting a beat");

   // A result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("output register overwritten while stalled");

   // The divider runs until its final step
   a_divide_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE && !status.div_last) |=> (state_ff == DIVIDE))
      else $error("division left early");

   // At most one command at a time
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

endmodule

FILE: hdl/sqd_datapath.sv
`timescale 1ns / 1ps
// Datapath for the scalar quantizer distortion unit: registers, quantizer, squarer,
// saturating accumulator, bit-serial divider and output register. Depends on sqd_pkg.
module sqd_datapath #(
   parameter int LEVELS      = 4,
   parameter int MAX_RUN     = 65535,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [sqd_pkg::CSR_ADDR_W-1:0]         csr_index,
   input  logic [sqd_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic signed [sqd_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                                   req_last_sample,
   input  sqd_pkg::sqd_cmd_type                   cmd,
   output sqd_pkg::sqd_status_type                status,
   output logic [sqd_pkg::INDEX_W-1:0]            rsp_level_index,
   output logic signed [sqd_pkg::CODE_W-1:0]      rsp_quantized_value,
   output logic                                   rsp_run_end,
   output logic [sqd_pkg::MEAN_W-1:0]             rsp_mean_sq_error
);
   import sqd_pkg::*;

   localparam int COUNT_BITS = $clog2(MAX_RUN + 1);
   localparam int STEP_BITS  = $clog2(SUM_W);
   localparam bit SIGNED_IN  = (SAMPLE_BITS <= SAMPLE_W);
   localparam int SIGN_POS   = SIGNED_IN ? SAMPLE_BITS - 1 : SAMPLE_W - 1;
   localparam logic [COUNT_BITS-1:0] RUN_LIMIT = COUNT_BITS'(MAX_RUN);
   localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(SUM_W - 1);

   // Configuration registers
   logic [CSR_DATA_W-1:0] thr_ff  [NUM_THRESH];
   logic [CSR_DATA_W-1:0] thr_in  [NUM_THRESH];
   logic [CSR_DATA_W-1:0] code_ff [NUM_CODES];
   logic [CSR_DATA_W-1:0] code_in [NUM_CODES];

   // Item stages
   logic signed [VALUE_W-1:0] sample_ext;
   logic signed [VALUE_W-1:0] thr_ext [NUM_THRESH];
   logic signed [VALUE_W-1:0] code_ext;
   logic [INDEX_W-1:0]        idx;
   logic                      stop;
   logic                      fill;
   logic [INDEX_W-1:0]        idx_ff;
   logic [CODE_W-1:0]         cv_ff;
   logic signed [VALUE_W-1:0] diff_ff;
   logic                      last_ff;
   logic [VALUE_W-1:0]        diff_neg;
   logic [ABS_W-1:0]          abs_err;
   logic [SQ_W-1:0]           sq_ff;

   // Accumulator
   logic [SUM_W-1:0]      sum_ff, sum_in, sum_upd;
   logic [SUM_W:0]        sum_wide;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_upd;
   logic                  room;

   // Divider
   logic [COUNT_BITS-1:0] rem_ff, divisor_ff;
   logic [SUM_W-1:0]      quot_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS:0]   trial;
   logic                  ge;
   logic [MEAN_W-1:0]     mean;

   // Output register
   logic [INDEX_W-1:0] out_idx_ff;
   logic [CODE_W-1:0]  out_cv_ff;
   logic               out_end_ff;
   logic [MEAN_W-1:0]  out_mean_ff;

   // Register writes; unknown indexes drop
   always_comb begin
      thr_in  = thr_ff;
      code_in = code_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD_0:  thr_in[0]  = csr_wdata;
            CSR_THRESHOLD_1:  thr_in[1]  = csr_wdata;
            CSR_THRESHOLD_2:  thr_in[2]  = csr_wdata;
            CSR_CODE_VALUE_0: code_in[0] = csr_wdata;
            CSR_CODE_VALUE_1: code_in[1] = csr_wdata;
            CSR_CODE_VALUE_2: code_in[2] = csr_wdata;
            CSR_CODE_VALUE_3: code_in[3] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0]  <= THRESHOLD_0_RESET;
         thr_ff[1]  <= THRESHOLD_1_RESET;
         thr_ff[2]  <= THRESHOLD_2_RESET;
         code_ff[0] <= CODE_VALUE_0_RESET;
         code_ff[1] <= CODE_VALUE_1_RESET;
         code_ff[2] <= CODE_VALUE_2_RESET;
         code_ff[3] <= CODE_VALUE_3_RESET;
      end else begin
         thr_ff  <= thr_in;
         code_ff <= code_in;
      end
   end

   // Take the low SAMPLE_BITS bits of the sample as two's complement
   always_comb begin
      fill = SIGNED_IN ? req_sample[SIGN_POS] : 1'b0;
      for (int b = 0; b < SAMPLE_W; b++) begin
         sample_ext[b] = (b < SAMPLE_BITS) ? req_sample[b] : fill;
      end
      sample_ext[VALUE_W-1:SAMPLE_W] = {(VALUE_W - SAMPLE_W){fill}};
   end

   // Scan thresholds in order, stop at the first one not below the sample
   always_comb begin
      idx  = '0;
      stop = 1'b0;
      for (int k = 0; k < NUM_THRESH; k++) begin
         thr_ext[k] = {{(VALUE_W - CSR_DATA_W){thr_ff[k][CSR_DATA_W-1]}}, thr_ff[k]};
      end
      for (int k = 0; k < LEVELS - 1; k++) begin
         if (!stop) begin
            if (thr_ext[k] < sample_ext) begin
               idx = idx + INDEX_W'(1);
            end else begin
               stop = 1'b1;
            end
         end
      end
      code_ext = {{(VALUE_W - CODE_W){code_ff[idx][CODE_W-1]}}, code_ff[idx]};
   end

   // Capture the beat with its index, code word and error
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff  <= idx;
         cv_ff   <= code_ff[idx];
         diff_ff <= sample_ext - code_ext;
         last_ff <= req_last_sample;
      end
   end

   // Square the magnitude of the error
   assign diff_neg = -diff_ff;
   assign abs_err  = diff_ff[VALUE_W-1] ? diff_neg[ABS_W-1:0] : diff_ff[ABS_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_ff <= abs_err * abs_err;
      end
   end

   // Saturating sum; freeze once the run reaches its limit
   always_comb begin
      room      = (count_ff < RUN_LIMIT);
      sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
      sum_upd   = sum_ff;
      count_upd = count_ff;
      if (room) begin
         sum_upd   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         count_upd = count_ff + COUNT_BITS'(1);
      end
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.accumulate) begin
         sum_in   = last_ff ? '0 : sum_upd;
         count_in = last_ff ? '0 : count_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // Restoring division, one quotient bit per step
   assign shifted = {rem_ff, quot_ff[SUM_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign ge      = (shifted >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (cmd.accumulate && last_ff) begin
         rem_ff     <= '0;
         quot_ff    <= sum_upd;
         divisor_ff <= count_upd;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         quot_ff <= {quot_ff[SUM_W-2:0], ge};
         step_ff <= step_ff + STEP_BITS'(1);
      end
   end

   assign status.last     = last_ff;
   assign status.div_last = (step_ff == STEP_LAST);

   // Clamp the mean to 32 bits; zero unless the run ends here
   always_comb begin
      mean = '0;
      if (last_ff) begin
         mean = (quot_ff[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}} : quot_ff[MEAN_W-1:0];
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_idx_ff  <= idx_ff;
         out_cv_ff   <= cv_ff;
         out_end_ff  <= last_ff;
         out_mean_ff <= mean;
      end
   end

   assign rsp_level_index     = out_idx_ff;
   assign rsp_quantized_value = out_cv_ff;
   assign rsp_run_end         = out_end_ff;
   assign rsp_mean_sq_error   = out_mean_ff;

endmodule

FILE: hdl/scalar_quantizer_distortion_unit.sv
`timescale 1ns / 1ps
// Top level of the scalar quantizer distortion unit: controller plus datapath.
// Depends on sqd_pkg, sqd_ctrl and sqd_datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_sample, req_last_sample
//   rsp       out         rsp_valid / rsp_stall  rsp_level_index, rsp_quantized_value,
//                                                rsp_run_end, rsp_mean_sq_error
//   csr       in          csr_write_en           csr_index, csr_wdata
//
// An ordinary item goes from accept to the next accept through capture and compare,
// square, accumulate and the load of the output register.
// An item marked last adds the bit-serial divider before that load (one quotient bit
// per cycle over the 48-bit sum).
// Reset is synchronous; it restores the register defaults and clears sum and count.
// One output register holds a waiting result; the next item is accepted meanwhile and
// waits at its output load while that beat stays stalled.
module scalar_quantizer_distortion_unit #(
   parameter int LEVELS      = 4,
   parameter int MAX_RUN     = 65535,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [sqd_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [sqd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sqd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sqd_pkg::INDEX_W-1:0]         rsp_level_index,
   output logic signed [sqd_pkg::CODE_W-1:0]   rsp_quantized_value,
   output logic                                rsp_run_end,
   output logic [sqd_pkg::MEAN_W-1:0]          rsp_mean_sq_error
);
   import sqd_pkg::*;

   sqd_cmd_type    cmd;
   sqd_status_type status;

   // Sequencer
   sqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage
   sqd_datapath #(
      .LEVELS      (LEVELS),
      .MAX_RUN     (MAX_RUN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .cmd                 (cmd),
      .status              (status),
      .rsp_level_index     (rsp_level_index),
      .rsp_quantized_value (rsp_quantized_value),
      .rsp_run_end         (rsp_run_end),
      .rsp_mean_sq_error   (rsp_mean_sq_error)
   );

endmodule

FILE: sim/sqd_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the scalar quantizer distortion unit: mirrors the registers and the
// error accumulator, predicts each response beat and compares it field by field.
// Depends on sqd_pkg for the register map and reset values.
module sqd_result_checker #(
   parameter int LEVELS  = 4,
   parameter int MAX_RUN = 65535
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [sqd_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [sqd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [sqd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [sqd_pkg::INDEX_W-1:0]         rsp_level_index,
   input  logic signed [sqd_pkg::CODE_W-1:0]   rsp_quantized_value,
   input  logic                                rsp_run_end,
   input  logic [sqd_pkg::MEAN_W-1:0]          rsp_mean_sq_error,
   output int                                  pending_results,
   output int                                  mismatch_count,
   output int                                  results_checked
);
   import sqd_pkg::*;

   localparam longint unsigned ERR_SUM_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned MSE_MAX     = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [INDEX_W-1:0]       level;
      logic signed [CODE_W-1:0] value;
      logic                     run_end;
      logic [MEAN_W-1:0]        mse;
   } quant_result_type;

   // Mirror of the configuration and the running error state
   logic signed [SAMPLE_W-1:0] thresh [NUM_THRESH];
   logic signed [CODE_W-1:0]   code   [NUM_CODES];
   longint unsigned            err_total;
   int unsigned                samples_in_run;

   quant_result_type expected_q [$];
   int               mismatch_total;
   int               checked_total;

   // Quantize one sample, fold its squared error into the run, report the mean on a last beat
   function automatic quant_result_type quantize_sample(input logic signed [SAMPLE_W-1:0] s,
                                                        input logic closes_run);
      quant_result_type           r;
      logic [INDEX_W-1:0]         level;
      logic signed [VALUE_W-1:0]  diff;
      longint unsigned            mag;
      longint unsigned            sq;
      longint unsigned            mean;
      level = '0;
      for (int k = 0; k < LEVELS - 1; k++) begin
         if (thresh[k] < s) begin
            level++;
         end else begin
            break;
         end
      end
      diff = s - code[level];
      mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
      sq   = mag * mag;
      // Freeze sum and count once the run reaches its limit
      if (samples_in_run < MAX_RUN) begin
         if (sq > ERR_SUM_MAX - err_total) begin
            err_total = ERR_SUM_MAX;
         end else begin
            err_total += sq;
         end
         samples_in_run++;
      end
      mean = 0;
      if (closes_run) begin
         if (samples_in_run != 0) begin
            mean = err_total / longint'(samples_in_run);
         end
         if (mean > MSE_MAX) begin
            mean = MSE_MAX;
         end
         err_total      = 0;
         samples_in_run = 0;
      end
      r.level   = level;
      r.value   = code[level];
      r.run_end = closes_run;
      r.mse     = mean[MEAN_W-1:0];
      return r;
   endfunction

   // Track writes, predict accepted request beats, check accepted response beats
   always @(posedge clock) begin
      quant_result_type want;
      quant_result_type got;
      if (reset) begin
         thresh[0]      = THRESHOLD_0_RESET;
         thresh[1]      = THRESHOLD_1_RESET;
         thresh[2]      = THRESHOLD_2_RESET;
         code[0]        = CODE_VALUE_0_RESET;
         code[1]        = CODE_VALUE_1_RESET;
         code[2]        = CODE_VALUE_2_RESET;
         code[3]        = CODE_VALUE_3_RESET;
         err_total      = 0;
         samples_in_run = 0;
         expected_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_THRESHOLD_0:  thresh[0] = csr_wdata;
               CSR_THRESHOLD_1:  thresh[1] = csr_wdata;
               CSR_THRESHOLD_2:  thresh[2] = csr_wdata;
               CSR_CODE_VALUE_0: code[0]   = csr_wdata;
               CSR_CODE_VALUE_1: code[1]   = csr_wdata;
               CSR_CODE_VALUE_2: code[2]   = csr_wdata;
               CSR_CODE_VALUE_3: code[3]   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(quantize_sample(req_sample, req_last_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_level_index, rsp_quantized_value, rsp_run_end, rsp_mean_sq_error};
            checked_total++;
            if (expected_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("%t: unexpected beat idx %0d val %0d end %0b mse %0d", $realtime,
                           got.level, got.value, got.run_end, got.mse);
               end
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("%t: beat %0d got idx %0d val %0d end %0b mse %0d", $realtime,
                              checked_total, got.level, got.value, got.run_end, got.mse);
                     $display("   expected idx %0d val %0d end %0b mse %0d",
                              want.level, want.value, want.run_end, want.mse);
                  end
               end
            end
         end
      end
      pending_results <= expected_q.size();
      mismatch_count  <= mismatch_total;
      results_checked <= checked_total;
   end

   initial begin
      mismatch_total = 0;
      checked_total  = 0;
   end

endmodule

FILE: sim/scalar_quantizer_distortion_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the scalar quantizer distortion unit: clock, reset, register writes,
// request and response stimulus, final verdict. Depends on sqd_pkg and sqd_result_checker.
module scalar_quantizer_distortion_unit_test;
   import sqd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_ITEMS    = 200;
   localparam int LONG_RUN_ITEMS = 64;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_write_en;
   logic [CSR_ADDR_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_sample;
   logic                        req_last_sample;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [INDEX_W-1:0]          rsp_level_index;
   logic signed [CODE_W-1:0]    rsp_quantized_value;
   logic                        rsp_run_end;
   logic [MEAN_W-1:0]           rsp_mean_sq_error;

   int pending_results;
   int mismatch_count;
   int results_checked;

   // Stimulus bookkeeping
   bit                          idle_on;
   int                          hold_requests;
   int                          holds_served;
   int                          samples_sent;
   int                          runs_closed;
   int                          settings_loaded;
   int                          run_left;
   logic signed [SAMPLE_W-1:0]  thr_now  [NUM_THRESH];
   logic signed [CODE_W-1:0]    code_now [NUM_CODES];

   scalar_quantizer_distortion_unit dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_index     (rsp_level_index),
      .rsp_quantized_value (rsp_quantized_value),
      .rsp_run_end         (rsp_run_end),
      .rsp_mean_sq_error   (rsp_mean_sq_error)
   );

   sqd_result_checker result_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_index     (rsp_level_index),
      .rsp_quantized_value (rsp_quantized_value),
      .rsp_run_end         (rsp_run_end),
      .rsp_mean_sq_error   (rsp_mean_sq_error),
      .pending_results     (pending_results),
      .mismatch_count      (mismatch_count),
      .results_checked     (results_checked)
   );

   always #1 clock = ~clock;

   // Offer one request beat and hold it until accepted
   task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic closes_run);
      if (idle_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= closes_run;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      if (closes_run) begin
         runs_closed++;
      end
   endtask

   // Stop offering and wait until every predicted beat has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   // Load all thresholds and code words from the shadow copy
   task automatic program_registers();
      write_reg(CSR_THRESHOLD_0,  thr_now[0]);
      write_reg(CSR_THRESHOLD_1,  thr_now[1]);
      write_reg(CSR_THRESHOLD_2,  thr_now[2]);
      write_reg(CSR_CODE_VALUE_0, code_now[0]);
      write_reg(CSR_CODE_VALUE_1, code_now[1]);
      write_reg(CSR_CODE_VALUE_2, code_now[2]);
      write_reg(CSR_CODE_VALUE_3, code_now[3]);
      csr_write_en <= 1'b0;
      settings_loaded++;
   endtask

   // Draw a random partition and codebook; keep the partition ascending when asked
   task automatic pick_settings(input bit ordered);
      logic signed [SAMPLE_W-1:0] swap_val;
      for (int i = 0; i < NUM_THRESH; i++) begin
         thr_now[i] = 16'($urandom());
      end
      for (int i = 0; i < NUM_CODES; i++) begin
         code_now[i] = 16'($urandom());
      end
      if (ordered) begin
         repeat (2) begin
            for (int i = 0; i < NUM_THRESH - 1; i++) begin
               if (thr_now[i] > thr_now[i+1]) begin
                  swap_val     = thr_now[i];
                  thr_now[i]   = thr_now[i+1];
                  thr_now[i+1] = swap_val;
               end
            end
         end
      end
   endtask

   // Mix of samples near a boundary, at the range ends or around zero, and anywhere
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 30) begin
         return thr_now[$urandom_range(NUM_THRESH - 1)] + 16'($urandom_range(4)) - 16'sd2;
      end else if (sel < 40) begin
         case ($urandom_range(3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return 16'($urandom());
   endfunction

   // Response side: random stalls, plus a long hold-off when requested
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= idle_on && ($urandom_range(99) < 13);
      end
   end

   initial begin
      #4_000_000;
      $display("scalar_quantizer_distortion_unit: mismatch");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_THRESHOLD_0;
      csr_wdata       <= '0;
      req_valid       <= 1'b0;
      req_sample      <= '0;
      req_last_sample <= 1'b0;
      idle_on         = 1'b1;
      hold_requests   = 0;
      holds_served    = 0;
      samples_sent    = 0;
      runs_closed     = 0;
      settings_loaded = 0;
      run_left        = 0;
      thr_now  = '{THRESHOLD_0_RESET, THRESHOLD_1_RESET, THRESHOLD_2_RESET};
      code_now = '{CODE_VALUE_0_RESET, CODE_VALUE_1_RESET, CODE_VALUE_2_RESET,
                   CODE_VALUE_3_RESET};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset partition: range ends, each boundary and its neighbor, a one-sample run
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh7FFF, 1'b0);
      send_beat(-16'sd16384, 1'b0);
      send_beat(-16'sd16383, 1'b0);
      send_beat(16'sd0, 1'b0);
      send_beat(16'sd1, 1'b0);
      send_beat(16'sd16384, 1'b0);
      send_beat(16'sd16385, 1'b0);
      send_beat(-16'sd1, 1'b1);
      send_beat(16'sd5, 1'b1);
      wait_for_results();

      // Write to an unmapped index must leave every register alone
      write_reg(CSR_UNMAPPED, 16'h7FFF);

      // Largest possible error on every sample: mean at its largest, still below the clamp
      thr_now  = '{16'sh8000, 16'sh8000, 16'sh8000};
      code_now = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000};
      program_registers();
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh7FFF, 1'b1);
      wait_for_results();

      // Unsorted partition: scan stops at the first boundary not below the sample
      thr_now  = '{16'sd0, -16'sd20000, 16'sd30000};
      code_now = '{16'sh8000, 16'sd100, -16'sd100, 16'sh7FFF};
      program_registers();
      send_beat(16'sd10, 1'b0);
      send_beat(-16'sd5, 1'b0);
      send_beat(16'sd30001, 1'b0);
      send_beat(16'sd0, 1'b1);
      wait_for_results();

      // Boundaries all at the top: nothing is ever above them
      thr_now  = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      code_now = '{16'sd0, 16'sd1, 16'sd2, 16'sd3};
      program_registers();
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh8000, 1'b1);
      wait_for_results();

      // One long run with no idling, then a short run to see the clear
      idle_on  = 1'b0;
      thr_now  = '{THRESHOLD_0_RESET, THRESHOLD_1_RESET, THRESHOLD_2_RESET};
      code_now = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
      program_registers();
      for (int n = 0; n < LONG_RUN_ITEMS; n++) begin
         send_beat(16'($urandom()), n == LONG_RUN_ITEMS - 1);
      end
      send_beat(16'($urandom()), 1'b0);
      send_beat(16'($urandom()), 1'b1);
      wait_for_results();

      // Random phases with random run lengths under several settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_on = (p != 1);
         case (p)
            2:       pick_settings(1'b0);
            3: begin
               pick_settings(1'b1);
               thr_now[1] = thr_now[0];
            end
            4: begin
               thr_now  = '{THRESHOLD_0_RESET, THRESHOLD_1_RESET, THRESHOLD_2_RESET};
               code_now = '{CODE_VALUE_0_RESET, CODE_VALUE_1_RESET, CODE_VALUE_2_RESET,
                            CODE_VALUE_3_RESET};
            end
            default: pick_settings(1'b1);
         endcase
         program_registers();
         // Back-pressure: response side holds off while requests keep coming
         if (p == 2 || p == 4) begin
            hold_requests++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (run_left == 0) begin
               run_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
            end
            run_left--;
            send_beat(pick_sample(), run_left == 0);
         end
         wait_for_results();
      end

      repeat (64) @(posedge clock);
      $display("Sent %0d samples in %0d closed runs under %0d register settings.",
               samples_sent, runs_closed, settings_loaded);
      $display("Checked %0d result beats, including unsorted and saturated partitions.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("scalar_quantizer_distortion_unit: match");
      end else begin
         $display("scalar_quantizer_distortion_unit: mismatch");
      end
      $finish;
   end

endmodule
